// File: design/led_fade_and_blink_notifier_defines.svh
// Assertion macros for the notifier block
`ifndef LED_FADE_AND_BLINK_NOTIFIER_DEFINES_SVH
`define LED_FADE_AND_BLINK_NOTIFIER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LFB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lfb assertion failed");
`define LFB_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("lfb forbidden condition");
`else
`define LFB_ASSERT(lbl, prop)
`define LFB_ASSERT_NEVER(lbl, cond)
`endif

`endif

// File: design/lfb_pkg.sv
`timescale 1ns / 1ps
package lfb_pkg;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_NOTIFY = 2'd1,
    OP_WEAK   = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    CFG_RAMP_MAX   = 3'd0,
    CFG_RAMP_MIN   = 3'd1,
    CFG_RAMP_STEP  = 3'd2,
    CFG_BLINK_EN   = 3'd3,
    CFG_BLINK_ON   = 3'd4,
    CFG_BLINK_OFF  = 3'd5,
    CFG_BLINK_RGB  = 3'd6
  } cfg_idx_e;

  localparam int unsigned NumLanes = 3;
  localparam logic [7:0] HoldDefault = 8'd3;
  localparam logic [8:0] LitReload = 9'h1FF;

  // what the lanes and the merge stage need for one tick
  typedef struct packed {
    logic        bypass;
    logic [23:0] bypass_rgb;
    logic [23:0] fade_rgb;
    logic [3:0]  level;
    logic        fading;
  } tick_info_t;

endpackage

// File: design/lfb_lane.sv
`timescale 1ns / 1ps
module lfb_lane (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [7:0] chan_i,
  input  logic [3:0] level_i,
  output logic       done_o,
  output logic [7:0] value_o
);
  logic [2:0]  vld_q;
  logic [7:0]  chan_q;
  logic [7:0]  sq_q;
  logic [15:0] prod_q;
  logic [7:0]  val_q;
  logic [16:0] sum;
  logic [8:0]  est;
  logic [16:0] rem;
  logic [8:0]  quo;

  // c * lvl^2 / 255: estimate from x + x/256, then one correction step
  always_comb begin
    sum = {1'b0, prod_q} + {9'd0, prod_q[15:8]};
    est = sum[16:8];
    rem = {1'b0, prod_q} - (({8'd0, est} << 8) - {8'd0, est});
    quo = (rem >= 17'd255) ? est + 9'd1 : est;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      chan_q <= chan_i;
      sq_q   <= {4'd0, level_i} * {4'd0, level_i};
    end
    if (vld_q[0]) begin
      prod_q <= {8'd0, chan_q} * {8'd0, sq_q};
    end
    if (vld_q[1]) begin
      val_q <= quo[7:0];
    end
  end

  assign done_o  = vld_q[2];
  assign value_o = val_q;
endmodule

// File: design/lfb_seq.sv
`timescale 1ns / 1ps
module lfb_seq (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        item_acc_i,
  input  logic [1:0]  op_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  hold_i,
  output lfb_pkg::tick_info_t info_o
);
  import lfb_pkg::*;

  logic [3:0]  ramp_max_q, ramp_min_q, ramp_step_q;
  logic        blink_en_q;
  logic [7:0]  blink_on_q, blink_off_q;
  logic [23:0] blink_rgb_q;

  logic        active_q, active_d;
  logic        rising_q, rising_d;
  logic [3:0]  level_q, level_d;
  logic [7:0]  pause_q, pause_d;
  logic [7:0]  hold_q, hold_d;
  logic [23:0] color_q, color_d;
  logic [8:0]  lit_q, lit_d;
  logic [7:0]  dark_q, dark_d;

  always_comb begin
    logic start;
    logic [8:0] lit_v;
    logic [7:0] dark_v;
    logic [23:0] rgb_v;
    start    = 1'b0;
    lit_v    = lit_q;
    dark_v   = dark_q;
    rgb_v    = '0;
    active_d = active_q;
    rising_d = rising_q;
    level_d  = level_q;
    pause_d  = pause_q;
    hold_d   = hold_q;
    color_d  = color_q;
    lit_d    = lit_q;
    dark_d   = dark_q;
    case (op_i)
      OP_NOTIFY: start = 1'b1;
      OP_WEAK:   start = !active_q;
      OP_TICK: begin
        if (!active_q) begin
          if (blink_en_q) begin
            if (lit_v == LitReload) begin
              lit_v  = {1'b0, blink_on_q};
              dark_v = '0;
            end
            if (lit_v != '0) begin
              lit_v = lit_v - 9'd1;
              rgb_v = blink_rgb_q;
            end else if (dark_v != '0) begin
              dark_v = dark_v - 8'd1;
            end else begin
              lit_v  = {1'b0, blink_on_q};
              dark_v = blink_off_q;
            end
          end else begin
            lit_v  = LitReload;
            dark_v = '0;
          end
          lit_d  = lit_v;
          dark_d = dark_v;
        end else if (pause_q == '0) begin
          if (rising_q) begin
            if ({1'b0, level_q} + {1'b0, ramp_step_q} >= {1'b0, ramp_max_q}) begin
              rising_d = 1'b0;
              pause_d  = hold_q;
            end else begin
              level_d = level_q + ramp_step_q;
            end
          end else begin
            if ({1'b0, level_q} <= {1'b0, ramp_min_q} + {1'b0, ramp_step_q}) begin
              active_d = 1'b0;
              level_d  = '0;
            end else begin
              level_d = level_q - ramp_step_q;
            end
          end
        end else begin
          pause_d = pause_q - 8'd1;
        end
      end
      default: ;
    endcase
    if (start) begin
      color_d  = {red_i, green_i, blue_i};
      rising_d = 1'b1;
      active_d = 1'b1;
      level_d  = ramp_min_q;
      pause_d  = '0;
      hold_d   = (hold_i == '0) ? HoldDefault : hold_i;
    end
    info_o.bypass     = !active_q;
    info_o.bypass_rgb = rgb_v;
    info_o.fade_rgb   = color_q;
    info_o.level      = level_d;
    info_o.fading     = active_q & active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_max_q  <= 4'd10;
      ramp_min_q  <= 4'd0;
      ramp_step_q <= 4'd2;
      blink_en_q  <= 1'b0;
      blink_on_q  <= '0;
      blink_off_q <= '0;
      blink_rgb_q <= '0;
      active_q    <= 1'b0;
      rising_q    <= 1'b1;
      level_q     <= '0;
      pause_q     <= '0;
      hold_q      <= HoldDefault;
      color_q     <= '0;
      lit_q       <= '0;
      dark_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_RAMP_MAX:  ramp_max_q  <= cfg_wdata_i[3:0];
          CFG_RAMP_MIN:  ramp_min_q  <= cfg_wdata_i[3:0];
          CFG_RAMP_STEP: ramp_step_q <= cfg_wdata_i[3:0];
          CFG_BLINK_EN:  blink_en_q  <= cfg_wdata_i[0];
          CFG_BLINK_ON:  blink_on_q  <= cfg_wdata_i[7:0];
          CFG_BLINK_OFF: blink_off_q <= cfg_wdata_i[7:0];
          CFG_BLINK_RGB: blink_rgb_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (item_acc_i) begin
        active_q <= active_d;
        rising_q <= rising_d;
        level_q  <= level_d;
        pause_q  <= pause_d;
        hold_q   <= hold_d;
        color_q  <= color_d;
        lit_q    <= lit_d;
        dark_q   <= dark_d;
      end
    end
  end
endmodule

// File: design/led_fade_and_blink_notifier.sv
// Flow: a tick passes through the three-stage scale lanes (level square,
//   channel multiply, divide by 255), then the output register, which holds
//   while m_axis_tready is low; no item is taken until the tick is loaded there.
// Notify items complete in their cycle.
// Reset: asynchronous active low; registers and sequencer state take their
//   reset values, output empty, ready after reset release.
`timescale 1ns / 1ps
`include "led_fade_and_blink_notifier_defines.svh"
module led_fade_and_blink_notifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // red, green, blue, hold_request
  input  logic [1:0]  s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // out_red, out_green, out_blue
  output logic        m_axis_tuser   // fading
);
  import lfb_pkg::*;

  logic                 in_acc;
  logic                 tick_start;
  tick_info_t           info;
  tick_info_t           info_q;
  logic                 busy_q;
  logic                 res_rdy_q;
  logic [NumLanes-1:0]  lane_done;
  logic [7:0]           lane_val [NumLanes];
  logic [7:0]           lane_chan [NumLanes];
  logic                 pend;
  logic                 load;
  logic                 out_vld_q;
  logic [23:0]          out_rgb_q;
  logic                 out_fading_q;

  assign s_axis_tready = !busy_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign tick_start    = in_acc && (s_axis_tuser == OP_TICK);

  lfb_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_acc_i  (in_acc),
    .op_i        (s_axis_tuser),
    .red_i       (s_axis_tdata[7:0]),
    .green_i     (s_axis_tdata[15:8]),
    .blue_i      (s_axis_tdata[23:16]),
    .hold_i      (s_axis_tdata[31:24]),
    .info_o      (info)
  );

  assign lane_chan[0] = info.fade_rgb[23:16];
  assign lane_chan[1] = info.fade_rgb[15:8];
  assign lane_chan[2] = info.fade_rgb[7:0];

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    lfb_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (tick_start),
      .chan_i  (lane_chan[g]),
      .level_i (info.level),
      .done_o  (lane_done[g]),
      .value_o (lane_val[g])
    );
  end

  assign pend = lane_done[0] || res_rdy_q;
  assign load = pend && (!out_vld_q || m_axis_tready);

  always_ff @(posedge clk_i) begin
    if (tick_start) begin
      info_q <= info;
    end
    if (load) begin
      // red in the low byte, blue in the high byte
      out_rgb_q    <= info_q.bypass ? {info_q.bypass_rgb[7:0], info_q.bypass_rgb[15:8],
                                       info_q.bypass_rgb[23:16]}
                                    : {lane_val[2], lane_val[1], lane_val[0]};
      out_fading_q <= info_q.fading;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      res_rdy_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      res_rdy_q <= pend && !load;
      if (tick_start) begin
        busy_q <= 1'b1;
      end else if (load) begin
        busy_q <= 1'b0;
      end
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_rgb_q;
  assign m_axis_tuser  = out_fading_q;

  `LFB_ASSERT(a_tick_busy, tick_start |=> busy_q)
  `LFB_ASSERT(a_pending_busy, res_rdy_q |-> busy_q)
  `LFB_ASSERT_NEVER(a_done_twice, lane_done[0] && res_rdy_q)
  `LFB_ASSERT(a_lanes_lockstep, lane_done[0] |-> (lane_done[1] && lane_done[2]))
endmodule
